/* rtl/ptc_pkg.sv */
// Shared types and constants for the pressure/temperature compensation block.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package ptc_pkg;

   // Compensation constants
   localparam int unsigned FINE_OFFSET = 128000;
   localparam int unsigned PRESS_FULL  = 1048576;
   localparam int unsigned DIV_SCALE   = 3125;
   localparam int unsigned ROUND_HALF  = 128;

   // One restoring step per quotient bit
   localparam int unsigned DIV_STAGES  = 64;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_TEMP_COEFFS  = 2'd0,
      CSR_PRESS_A      = 2'd1,
      CSR_PRESS_B      = 2'd2,
      CSR_PRESS_LAST   = 2'd3
   } csr_index_type;

   // Per-item data that rides alongside the divider
   typedef struct packed {
      logic [23:0] temp_centi;
      logic        invalid;
   } ptc_side_type;

endpackage

/* rtl/pressure_temperature_compensation.sv */
// Top level of the pressure/temperature compensation pipeline.
// Depends on ptc_pkg, ptc_mul64 and ptc_div.
`timescale 1ns / 1ps

// Usage:
//   Load the four coefficient registers through the csr_ port (csr_we,
//   csr_index, csr_wdata) while no item is in flight. Each req_ item carries
//   one raw temperature and one raw pressure count; each gives exactly one
//   rsp_ item with temperature in 0.01 degC, pressure in Pa as Q24.8
//   (saturated to 33 bits signed) and an invalid flag for a zero divisor.
//   An item can be taken every cycle while req_ready is high; the 64-step
//   signed divider is fully pipelined, one quotient bit per stage, and
//   sets most of the latency. The whole pipeline advances together
//   whenever the output register is empty or being read. When the receiver
//   holds rsp_ready low with a result waiting, every stage holds and
//   req_ready drops; nothing is lost.
//   Synchronous reset clears all valid bits and the coefficient registers.

module pressure_temperature_compensation
   import ptc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [19:0]        req_raw_temperature,
   input  logic [19:0]        req_raw_pressure,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [23:0] rsp_celsius_centi,
   output logic signed [32:0] rsp_pressure_q24_8,
   output logic               rsp_pressure_invalid,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [63:0]        csr_wdata
);

   localparam int unsigned PRE_STAGES  = 13;
   localparam int unsigned POST_STAGES = 6;

   // Coefficient registers
   logic [47:0] temp_coeffs_ff;
   logic [63:0] press_a_ff;
   logic [63:0] press_b_ff;
   logic [15:0] press_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_coeffs_ff <= '0;
         press_a_ff     <= '0;
         press_b_ff     <= '0;
         press_last_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_TEMP_COEFFS: temp_coeffs_ff <= csr_wdata[47:0];
            CSR_PRESS_A:     press_a_ff     <= csr_wdata;
            CSR_PRESS_B:     press_b_ff     <= csr_wdata;
            CSR_PRESS_LAST:  press_last_ff  <= csr_wdata[15:0];
            default:         ;
         endcase
      end
   end

   logic [15:0]        t1;
   logic signed [15:0] t2, t3;
   logic [15:0]        p1;
   logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;

   always_comb begin
      t1 = temp_coeffs_ff[15:0];
      t2 = $signed(temp_coeffs_ff[31:16]);
      t3 = $signed(temp_coeffs_ff[47:32]);
      p1 = press_a_ff[15:0];
      p2 = $signed(press_a_ff[31:16]);
      p3 = $signed(press_a_ff[47:32]);
      p4 = $signed(press_a_ff[63:48]);
      p5 = $signed(press_b_ff[15:0]);
      p6 = $signed(press_b_ff[31:16]);
      p7 = $signed(press_b_ff[47:32]);
      p8 = $signed(press_b_ff[63:48]);
      p9 = $signed(press_last_ff);
   end

   // Flow control: one enable for the whole pipeline
   logic en;
   logic accept;
   logic rsp_valid_ff;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;
   assign accept    = req_valid && en;

   logic [PRE_STAGES-1:0]  pre_vld_ff;
   logic [POST_STAGES-1:0] post_vld_ff;
   logic                   div_vld;

   // S1: first temperature products
   logic [31:0] a_val, d_val;
   logic [31:0] mul_a_in, dd_in;
   logic [31:0] mul_a_ff, dd_ff;
   logic [19:0] adcp1_ff;

   always_comb begin
      a_val    = 32'(req_raw_temperature[19:3]) - 32'({t1, 1'b0});
      d_val    = 32'(req_raw_temperature[19:4]) - 32'(t1);
      mul_a_in = 32'($signed(a_val) * t2);
      dd_in    = 32'($signed(d_val) * $signed(d_val));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mul_a_ff <= mul_a_in;
         dd_ff    <= dd_in;
         adcp1_ff <= req_raw_pressure;
      end
   end

   // S2: shifts and the T3 product
   logic signed [31:0] dd_sh;
   logic [31:0] tv1_in, tv2m_in;
   logic [31:0] tv1_ff, tv2m_ff;
   logic [19:0] adcp2_ff;

   always_comb begin
      dd_sh   = $signed(dd_ff) >>> 12;
      tv1_in  = 32'($signed(mul_a_ff) >>> 11);
      tv2m_in = 32'(dd_sh * t3);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tv1_ff   <= tv1_in;
         tv2m_ff  <= tv2m_in;
         adcp2_ff <= adcp1_ff;
      end
   end

   // S3: fine temperature
   logic [31:0] fine_in, fine_ff;
   logic [19:0] adcp3_ff;

   assign fine_in = tv1_ff + 32'($signed(tv2m_ff) >>> 14);

   always_ff @(posedge clock) begin
      if (en) begin
         fine_ff  <= fine_in;
         adcp3_ff <= adcp2_ff;
      end
   end

   // S4: centidegrees and pressure offset term
   logic [31:0]        f5;
   logic signed [32:0] x_in, x_ff;
   logic [23:0]        tc4_ff;
   logic [19:0]        adcp4_ff;

   always_comb begin
      f5   = 32'(fine_ff * 32'd5) + 32'(ROUND_HALF);
      x_in = 33'($signed(fine_ff)) - 33'(FINE_OFFSET);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tc4_ff   <= f5[31:8];
         x_ff     <= x_in;
         adcp4_ff <= adcp3_ff;
      end
   end

   // S5: partial products of x*x, x*P5, x*P2
   logic [15:0]        xl;
   logic signed [16:0] xh;
   logic signed [33:0] xhh_in, xhl_in, xhh_ff, xhl_ff;
   logic [31:0]        xll_in, xll_ff;
   logic signed [48:0] xp5_in, xp2_in, xp5_5_ff, xp2_5_ff;
   logic [23:0]        tc5_ff;
   logic [19:0]        adcp5_ff;

   always_comb begin
      xl     = x_ff[15:0];
      xh     = x_ff[32:16];
      xhh_in = xh * xh;
      xhl_in = xh * $signed({1'b0, xl});
      xll_in = xl * xl;
      xp5_in = x_ff * p5;
      xp2_in = x_ff * p2;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xhh_ff   <= xhh_in;
         xhl_ff   <= xhl_in;
         xll_ff   <= xll_in;
         xp5_5_ff <= xp5_in;
         xp2_5_ff <= xp2_in;
         tc5_ff   <= tc4_ff;
         adcp5_ff <= adcp4_ff;
      end
   end

   // S6: x*x modulo 2^64
   logic [63:0]        xx_in, xx_ff;
   logic signed [48:0] xp5_6_ff, xp2_6_ff;
   logic [23:0]        tc6_ff;
   logic [19:0]        adcp6_ff;

   assign xx_in = (64'(xhh_ff) << 32) + (64'(xhl_ff) << 17) + 64'(xll_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         xx_ff    <= xx_in;
         xp5_6_ff <= xp5_5_ff;
         xp2_6_ff <= xp2_5_ff;
         tc6_ff   <= tc5_ff;
         adcp6_ff <= adcp5_ff;
      end
   end

   // S7-S8: x*x*P6 and x*x*P3
   logic [63:0] m6, m3;

   ptc_mul64 u_mul_p6 (
      .clock (clock),
      .en    (en),
      .op_a  (xx_ff),
      .op_b  (17'(p6)),
      .prod  (m6)
   );

   ptc_mul64 u_mul_p3 (
      .clock (clock),
      .en    (en),
      .op_a  (xx_ff),
      .op_b  (17'(p3)),
      .prod  (m3)
   );

   logic signed [48:0] xp5_7_ff, xp2_7_ff, xp5_8_ff, xp2_8_ff;
   logic [23:0]        tc7_ff, tc8_ff;
   logic [19:0]        adcp7_ff, adcp8_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         xp5_7_ff <= xp5_6_ff;
         xp2_7_ff <= xp2_6_ff;
         tc7_ff   <= tc6_ff;
         adcp7_ff <= adcp6_ff;
         xp5_8_ff <= xp5_7_ff;
         xp2_8_ff <= xp2_7_ff;
         tc8_ff   <= tc7_ff;
         adcp8_ff <= adcp7_ff;
      end
   end

   // S9: v2 and first part of v1
   logic [63:0] v2_in, v1a_in, v2_ff, v1a_ff;
   logic [23:0] tc9_ff;
   logic [19:0] adcp9_ff;

   always_comb begin
      v2_in  = m6 + (64'(xp5_8_ff) << 17) + (64'(p4) << 35);
      v1a_in = 64'($signed(m3) >>> 8) + (64'(xp2_8_ff) << 12);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v2_ff    <= v2_in;
         v1a_ff   <= v1a_in;
         tc9_ff   <= tc8_ff;
         adcp9_ff <= adcp8_ff;
      end
   end

   // S10: offset v1, form the dividend before scaling
   logic [20:0] pp;
   logic [63:0] v1b_in, num_in, v1b_ff, num_ff;
   logic [23:0] tc10_ff;

   always_comb begin
      pp     = 21'(PRESS_FULL) - {1'b0, adcp9_ff};
      v1b_in = v1a_ff + 64'h0000_8000_0000_0000;
      num_in = (64'(pp) << 31) - v2_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v1b_ff  <= v1b_in;
         num_ff  <= num_in;
         tc10_ff <= tc9_ff;
      end
   end

   // S11-S12: times P1 and times the divide scale
   logic [63:0] m1, mn;

   ptc_mul64 u_mul_p1 (
      .clock (clock),
      .en    (en),
      .op_a  (v1b_ff),
      .op_b  ($signed({1'b0, p1})),
      .prod  (m1)
   );

   ptc_mul64 u_mul_scale (
      .clock (clock),
      .en    (en),
      .op_a  (num_ff),
      .op_b  ($signed(17'(DIV_SCALE))),
      .prod  (mn)
   );

   logic [23:0] tc11_ff, tc12_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         tc11_ff <= tc10_ff;
         tc12_ff <= tc11_ff;
      end
   end

   // S13: divisor and dividend
   logic [63:0]  v1_ff, n_ff;
   logic [23:0]  tc13_ff;
   ptc_side_type div_side;

   always_ff @(posedge clock) begin
      if (en) begin
         v1_ff   <= 64'($signed(m1) >>> 33);
         n_ff    <= mn;
         tc13_ff <= tc12_ff;
      end
   end

   always_comb begin
      div_side.temp_centi = tc13_ff;
      div_side.invalid    = (v1_ff == 64'h0);
   end

   // Valid bits ahead of the divider
   always_ff @(posedge clock) begin
      if (reset) begin
         pre_vld_ff <= '0;
      end else if (en) begin
         pre_vld_ff <= {pre_vld_ff[PRE_STAGES-2:0], accept};
      end
   end

   // Divider
   logic [63:0]  q;
   ptc_side_type q_side;

   ptc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (pre_vld_ff[PRE_STAGES-1]),
      .dividend (n_ff),
      .divisor  (v1_ff),
      .in_side  (div_side),
      .out_vld  (div_vld),
      .quotient (q),
      .out_side (q_side)
   );

   // P1: ph = p >>> 13, partial squares
   logic [63:0]  ph;
   logic [63:0]  ll_in, ll_ff;
   logic [31:0]  hl_in, hl_ff;
   logic [63:0]  q1_ff;
   ptc_side_type side1_ff;

   always_comb begin
      ph    = 64'($signed(q) >>> 13);
      ll_in = ph[31:0] * ph[31:0];
      hl_in = 32'(ph[63:32] * ph[31:0]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff    <= ll_in;
         hl_ff    <= hl_in;
         q1_ff    <= q;
         side1_ff <= q_side;
      end
   end

   // P2: ph*ph modulo 2^64
   logic [63:0]  phph_in, phph_ff;
   logic [63:0]  q2_ff;
   ptc_side_type side2_ff;

   assign phph_in = ll_ff + {hl_ff[30:0], 1'b0, 32'h0};

   always_ff @(posedge clock) begin
      if (en) begin
         phph_ff  <= phph_in;
         q2_ff    <= q1_ff;
         side2_ff <= side1_ff;
      end
   end

   // P3-P4: second-order corrections
   logic [63:0] m9, m8;

   ptc_mul64 u_mul_p9 (
      .clock (clock),
      .en    (en),
      .op_a  (phph_ff),
      .op_b  (17'(p9)),
      .prod  (m9)
   );

   ptc_mul64 u_mul_p8 (
      .clock (clock),
      .en    (en),
      .op_a  (q2_ff),
      .op_b  (17'(p8)),
      .prod  (m8)
   );

   logic [63:0]  q3_ff, q4_ff;
   ptc_side_type side3_ff, side4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         q3_ff    <= q2_ff;
         side3_ff <= side2_ff;
         q4_ff    <= q3_ff;
         side4_ff <= side3_ff;
      end
   end

   // P5: sum of pressure and corrections
   logic [63:0]  s1_in, s1_ff;
   ptc_side_type side5_ff;

   assign s1_in = q4_ff + 64'($signed(m9) >>> 25) + 64'($signed(m8) >>> 19);

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff    <= s1_in;
         side5_ff <= side4_ff;
      end
   end

   // P6: scale to Q24.8 and add P7 offset
   logic [63:0]  s2_in, s2_ff;
   ptc_side_type side6_ff;

   assign s2_in = 64'($signed(s1_ff) >>> 8) + (64'(p7) << 4);

   always_ff @(posedge clock) begin
      if (en) begin
         s2_ff    <= s2_in;
         side6_ff <= side5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         post_vld_ff <= '0;
      end else if (en) begin
         post_vld_ff <= {post_vld_ff[POST_STAGES-2:0], div_vld};
      end
   end

   // Output: saturate, force zero on invalid divisor
   logic        fits;
   logic [32:0] press_in, press_ff;
   logic [23:0] temp_ff;
   logic        inval_ff;

   always_comb begin
      fits = (s2_ff[63:32] == {32{s2_ff[32]}});
      if (side6_ff.invalid) begin
         press_in = 33'h0;
      end else if (fits) begin
         press_in = s2_ff[32:0];
      end else if (s2_ff[63]) begin
         press_in = 33'h1_0000_0000;
      end else begin
         press_in = 33'h0_FFFF_FFFF;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         press_ff <= press_in;
         temp_ff  <= side6_ff.temp_centi;
         inval_ff <= side6_ff.invalid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= post_vld_ff[POST_STAGES-1];
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_celsius_centi     = $signed(temp_ff);
   assign rsp_pressure_q24_8    = $signed(press_ff);
   assign rsp_pressure_invalid  = inval_ff;

endmodule

/* rtl/ptc_mul64.sv */
// Two-stage multiplier: low 64 bits of a 64-bit word times a signed 17-bit value.
// Split into two 32x17 partial products; uses ptc_pkg for house conventions.
`timescale 1ns / 1ps

module ptc_mul64
   import ptc_pkg::*;
(
   input  logic               clock,
   input  logic               en,
   input  logic [63:0]        op_a,
   input  logic signed [16:0] op_b,
   output logic [63:0]        prod
);

   logic signed [49:0] lo_in;
   logic signed [49:0] lo_ff;
   logic signed [48:0] hi_full;
   logic [31:0]        hi_in;
   logic [31:0]        hi_ff;
   logic [63:0]        prod_in;
   logic [63:0]        prod_ff;

   // Partial products: low half unsigned, high half only needs 32 bits
   always_comb begin
      lo_in   = $signed({1'b0, op_a[31:0]}) * op_b;
      hi_full = $signed(op_a[63:32]) * op_b;
      hi_in   = hi_full[31:0];
   end

   // Recombine modulo 2^64
   assign prod_in = {{14{lo_ff[49]}}, lo_ff} + {hi_ff, 32'h0};

   always_ff @(posedge clock) begin
      if (en) begin
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

/* rtl/ptc_div.sv */
// Pipelined signed 64-bit divider, truncating toward zero, one quotient bit per stage.
// Carries a ptc_side_type item alongside; uses ptc_pkg.
`timescale 1ns / 1ps

module ptc_div
   import ptc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         in_vld,
   input  logic [63:0]  dividend,
   input  logic [63:0]  divisor,
   input  ptc_side_type in_side,
   output logic         out_vld,
   output logic [63:0]  quotient,
   output ptc_side_type out_side
);

   logic [63:0]  rem_ff  [0:DIV_STAGES];
   logic [63:0]  dq_ff   [0:DIV_STAGES];
   logic [63:0]  den_ff  [0:DIV_STAGES];
   logic         neg_ff  [0:DIV_STAGES];
   ptc_side_type side_ff [0:DIV_STAGES];
   logic [DIV_STAGES:0] vld_ff;

   logic         na;
   logic         nb;
   logic [63:0]  q_in;
   logic [63:0]  q_ff;
   ptc_side_type qside_ff;
   logic         qvld_ff;

   // Entry: magnitudes and result sign
   assign na = dividend[63];
   assign nb = divisor[63];

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= 64'h0;
         dq_ff[0]   <= na ? (64'h0 - dividend) : dividend;
         den_ff[0]  <= nb ? (64'h0 - divisor) : divisor;
         neg_ff[0]  <= na ^ nb;
         side_ff[0] <= in_side;
      end
   end

   // Restoring steps
   for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_step
      logic [64:0] shifted;
      logic [64:0] diff;
      logic        take;

      always_comb begin
         shifted = {rem_ff[k-1], dq_ff[k-1][63]};
         diff    = shifted - {1'b0, den_ff[k-1]};
         take    = !diff[64];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= take ? diff[63:0] : shifted[63:0];
            dq_ff[k]   <= {dq_ff[k-1][62:0], take};
            den_ff[k]  <= den_ff[k-1];
            neg_ff[k]  <= neg_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // Sign fix-up
   assign q_in = neg_ff[DIV_STAGES] ? (64'h0 - dq_ff[DIV_STAGES]) : dq_ff[DIV_STAGES];

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff     <= q_in;
         qside_ff <= side_ff[DIV_STAGES];
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         qvld_ff <= 1'b0;
      end else if (en) begin
         vld_ff  <= {vld_ff[DIV_STAGES-1:0], in_vld};
         qvld_ff <= vld_ff[DIV_STAGES];
      end
   end

   assign out_vld  = qvld_ff;
   assign quotient = q_ff;
   assign out_side = qside_ff;

endmodule
